/* hw/rtl/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// Lidar scan packet collector package
// Shared constants, codes and word types of the lidar scan packet collector.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int LSP_ANGLE_COUNT = 360;

   localparam logic [7:0] SYNC_BYTE    = 8'hFA;
   localparam logic [7:0] INDEX_LOW    = 8'hA0;
   localparam logic [7:0] INDEX_HIGH   = 8'hF9;
   localparam logic [7:0] DIST_HI_MASK = 8'h3F;

   localparam logic ACT_SENSOR = 1'b0;
   localparam logic ACT_PULL   = 1'b1;

   localparam logic [4:0] PH_HUNT     = 5'd0;
   localparam logic [4:0] PH_INDEX    = 5'd1;
   localparam logic [4:0] PH_SPEED_LO = 5'd2;
   localparam logic [4:0] PH_SPEED_HI = 5'd3;
   localparam logic [4:0] PH_READ0    = 5'd4;
   localparam logic [4:0] PH_LAST     = 5'd19;

   localparam logic [1:0] HEAD_LAST = 2'd3;

   localparam logic [2:0] SUB_STR_LO  = 3'd0;
   localparam logic [2:0] SUB_STR_HI  = 3'd1;
   localparam logic [2:0] SUB_SPD_LO  = 3'd2;
   localparam logic [2:0] SUB_SPD_HI  = 3'd3;
   localparam logic [2:0] SUB_DIST_LO = 3'd4;
   localparam logic [2:0] SUB_DIST_HI = 3'd5;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } lsp_req_type;

   typedef struct packed {
      logic [7:0] host_byte;
      logic       frame_last;
   } lsp_rsp_type;

   typedef struct packed {
      logic        dist_we;
      logic        spd_we;
      logic [13:0] distance;
      logic [15:0] strength;
      logic [15:0] speed;
   } lsp_wr_type;

   typedef struct packed {
      logic [13:0] distance;
      logic [15:0] strength;
      logic [15:0] speed;
   } lsp_rd_type;

endpackage

/* hw/rtl/lsp_parser.sv */
// ----------------------------------------------------------------------------
// Lidar scan packet parser
// Hunts for sync, checks the index byte and turns packet bytes into table writes.
// ----------------------------------------------------------------------------
module lsp_parser
   import lsp_pkg::*;
#(
   parameter int ANGLE_COUNT = LSP_ANGLE_COUNT,
   localparam int AW = $clog2(ANGLE_COUNT),
   localparam int PKT_COUNT = ANGLE_COUNT / 4,
   localparam int PW = $clog2(PKT_COUNT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    rx_byte,
   output lsp_wr_type    wr,
   output logic [AW-1:0] dist_addr,
   output logic [PW-1:0] spd_addr,
   output logic          arm_dump
);

   localparam logic [1:0] RD_DIST_LO = 2'd0;
   localparam logic [1:0] RD_DIST_HI = 2'd1;
   localparam logic [1:0] RD_STR_LO  = 2'd2;
   localparam logic [1:0] RD_STR_HI  = 2'd3;

   logic [4:0]    phase_ff, phase_in;
   logic [PW-1:0] pkt_ff, pkt_in;
   logic [7:0]    low_ff, low_in;
   logic [13:0]   dist_ff, dist_in;
   logic [4:0]    rd_num;
   logic [7:0]    dist_hi;
   logic [7:0]    index_off;

   assign rd_num    = phase_ff - PH_READ0;
   assign dist_hi   = rx_byte & DIST_HI_MASK;
   assign index_off = rx_byte - INDEX_LOW;

   assign dist_addr = AW'({pkt_ff, rd_num[3:2]});
   assign spd_addr  = pkt_ff;

   always_comb begin
      phase_in    = phase_ff;
      pkt_in      = pkt_ff;
      low_in      = low_ff;
      dist_in     = dist_ff;
      arm_dump    = 1'b0;
      wr.dist_we  = 1'b0;
      wr.spd_we   = 1'b0;
      wr.distance = dist_ff;
      wr.strength = {rx_byte, low_ff};
      wr.speed    = {rx_byte, low_ff};
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == SYNC_BYTE) begin
                  phase_in = PH_INDEX;
               end
            end
            PH_INDEX: begin
               if (rx_byte >= INDEX_LOW && rx_byte <= INDEX_HIGH) begin
                  pkt_in   = PW'(index_off);
                  phase_in = PH_SPEED_LO;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SPEED_LO: begin
               low_in   = rx_byte;
               phase_in = PH_SPEED_HI;
            end
            PH_SPEED_HI: begin
               wr.spd_we = 1'b1;
               phase_in  = PH_READ0;
            end
            default: begin
               if (phase_ff >= PH_READ0 && phase_ff <= PH_LAST) begin
                  case (rd_num[1:0])
                     RD_DIST_LO: low_in = rx_byte;
                     RD_DIST_HI: dist_in = {dist_hi[5:0], low_ff};
                     RD_STR_LO:  low_in = rx_byte;
                     RD_STR_HI:  wr.dist_we = 1'b1;
                     default:    low_in = low_ff;
                  endcase
                  if (phase_ff == PH_LAST) begin
                     phase_in = PH_HUNT;
                     arm_dump = (pkt_ff == PW'(PKT_COUNT - 1));
                  end else begin
                     phase_in = phase_ff + 5'd1;
                  end
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pkt_ff   <= '0;
         low_ff   <= '0;
         dist_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pkt_ff   <= pkt_in;
         low_ff   <= low_in;
         dist_ff  <= dist_in;
      end
   end

endmodule

/* hw/rtl/lsp_tables.sv */
// ----------------------------------------------------------------------------
// Lidar scan tables
// Distance/strength and speed memories with a clearing pass after reset.
// ----------------------------------------------------------------------------
module lsp_tables
   import lsp_pkg::*;
#(
   parameter int ANGLE_COUNT = LSP_ANGLE_COUNT,
   localparam int AW = $clog2(ANGLE_COUNT),
   localparam int PKT_COUNT = ANGLE_COUNT / 4,
   localparam int PW = $clog2(PKT_COUNT)
) (
   input  logic          clock,
   input  logic          reset,
   input  lsp_wr_type    wr,
   input  logic [AW-1:0] wr_dist_addr,
   input  logic [PW-1:0] wr_spd_addr,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_angle,
   output lsp_rd_type    rd,
   output logic          clear_busy
);

   logic [29:0]   ds_mem [ANGLE_COUNT];
   logic [15:0]   spd_mem [PKT_COUNT];
   logic [29:0]   ds_rd_ff;
   logic [15:0]   spd_rd_ff;
   logic          clear_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          ds_we;
   logic [AW-1:0] ds_addr;
   logic [29:0]   ds_data;
   logic          spd_we;
   logic [PW-1:0] spd_addr;
   logic [15:0]   spd_data;
   logic [PW-1:0] spd_rd_addr;

   assign clear_busy  = clear_ff;
   assign spd_rd_addr = PW'(rd_angle >> 2);

   always_comb begin
      if (clear_ff) begin
         ds_we    = 1'b1;
         ds_addr  = clr_cnt_ff;
         ds_data  = '0;
         spd_we   = (clr_cnt_ff < AW'(PKT_COUNT));
         spd_addr = clr_cnt_ff[PW-1:0];
         spd_data = '0;
      end else begin
         ds_we    = wr.dist_we;
         ds_addr  = wr_dist_addr;
         ds_data  = {wr.distance, wr.strength};
         spd_we   = wr.spd_we;
         spd_addr = wr_spd_addr;
         spd_data = wr.speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clear_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(ANGLE_COUNT - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ds_we) begin
         ds_mem[ds_addr] <= ds_data;
      end
      if (rd_en) begin
         ds_rd_ff <= ds_mem[rd_angle];
      end
   end

   always_ff @(posedge clock) begin
      if (spd_we) begin
         spd_mem[spd_addr] <= spd_data;
      end
      if (rd_en) begin
         spd_rd_ff <= spd_mem[spd_rd_addr];
      end
   end

   assign rd.distance = ds_rd_ff[29:16];
   assign rd.strength = ds_rd_ff[15:0];
   assign rd.speed    = spd_rd_ff;

endmodule

/* hw/rtl/lsp_dump.sv */
// ----------------------------------------------------------------------------
// Lidar scan frame dump
// Walks the frame on host pulls, reads the tables and drives the result word.
// ----------------------------------------------------------------------------
module lsp_dump
   import lsp_pkg::*;
#(
   parameter int ANGLE_COUNT = LSP_ANGLE_COUNT,
   localparam int AW = $clog2(ANGLE_COUNT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pull,
   input  logic          arm,
   input  logic          rsp_stall,
   input  lsp_rd_type    rd,
   output logic          dump_pending,
   output logic          rd_en,
   output logic [AW-1:0] rd_angle,
   output logic          hold,
   output logic          rsp_valid,
   output lsp_rsp_type   rsp_payload
);

   logic          pend_ff;
   logic          head_ff;
   logic [1:0]    head_cnt_ff;
   logic [AW-1:0] angle_ff;
   logic [2:0]    sub_ff;
   logic          s1_valid_ff;
   logic          s1_head_ff;
   logic [2:0]    s1_sub_ff;
   logic          s1_last_ff;
   logic          out_valid_ff;
   lsp_rsp_type   out_ff;
   logic          take;
   logic          last_now;
   logic          s1_move;
   logic [7:0]    sel_byte;

   assign take     = pull && pend_ff;
   assign rd_en    = take && !head_ff;
   assign rd_angle = angle_ff;
   assign last_now = !head_ff && angle_ff == AW'(ANGLE_COUNT - 1) && sub_ff == SUB_DIST_HI;
   assign s1_move  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign hold     = s1_valid_ff && out_valid_ff && rsp_stall;

   assign dump_pending = pend_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_ff;

   always_comb begin
      if (s1_head_ff) begin
         sel_byte = SYNC_BYTE;
      end else begin
         case (s1_sub_ff)
            SUB_STR_LO:  sel_byte = rd.strength[7:0];
            SUB_STR_HI:  sel_byte = rd.strength[15:8];
            SUB_SPD_LO:  sel_byte = rd.speed[7:0];
            SUB_SPD_HI:  sel_byte = rd.speed[15:8];
            SUB_DIST_LO: sel_byte = rd.distance[7:0];
            SUB_DIST_HI: sel_byte = {2'b00, rd.distance[13:8]};
            default:     sel_byte = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         head_ff      <= 1'b1;
         head_cnt_ff  <= '0;
         angle_ff     <= '0;
         sub_ff       <= SUB_STR_LO;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (arm) begin
            pend_ff     <= 1'b1;
            head_ff     <= 1'b1;
            head_cnt_ff <= '0;
            angle_ff    <= '0;
            sub_ff      <= SUB_STR_LO;
         end else if (take) begin
            if (head_ff) begin
               head_cnt_ff <= head_cnt_ff + 2'd1;
               if (head_cnt_ff == HEAD_LAST) begin
                  head_ff <= 1'b0;
               end
            end else if (sub_ff == SUB_DIST_HI) begin
               sub_ff <= SUB_STR_LO;
               if (last_now) begin
                  pend_ff     <= 1'b0;
                  head_ff     <= 1'b1;
                  head_cnt_ff <= '0;
                  angle_ff    <= '0;
               end else begin
                  angle_ff <= angle_ff + 1'b1;
               end
            end else begin
               sub_ff <= sub_ff + 3'd1;
            end
         end
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_head_ff <= head_ff;
         s1_sub_ff  <= sub_ff;
         s1_last_ff <= last_now;
      end
      if (s1_move) begin
         out_ff.host_byte  <= sel_byte;
         out_ff.frame_last <= s1_last_ff;
      end
   end

   a_read_tracked: assert property (@(posedge clock) disable iff (reset)
      take |=> s1_valid_ff)
      else $error("pulled word did not enter the read stage");

   a_held_stage: assert property (@(posedge clock) disable iff (reset)
      hold |=> s1_valid_ff && $stable(s1_sub_ff) && $stable(s1_last_ff))
      else $error("read stage lost its word while the result was stalled");

   a_no_rearm: assert property (@(posedge clock) disable iff (reset)
      arm |-> !pend_ff)
      else $error("dump armed while a frame is still pending");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      !head_ff |-> angle_ff < AW'(ANGLE_COUNT) && sub_ff <= SUB_DIST_HI)
      else $error("frame position out of range");

endmodule

/* hw/rtl/lidar_scan_packet_collector.sv */
// ----------------------------------------------------------------------------
// Lidar scan packet collector
// Parses lidar packets into angle tables and streams a full scan to the host.
// Throughput is one word per cycle on either kind of input word while
// req_stall is low. A pulled frame byte is registered in the table read
// stage and then in the output register before it appears on rsp.
// After reset the tables are cleared in a pass over all ANGLE_COUNT entries,
// one entry per cycle, during which req_stall is high.
// ----------------------------------------------------------------------------
module lidar_scan_packet_collector
   import lsp_pkg::*;
#(
   parameter int ANGLE_COUNT = LSP_ANGLE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lsp_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lsp_rsp_type rsp_payload
);

   localparam int AW = $clog2(ANGLE_COUNT);
   localparam int PW = $clog2(ANGLE_COUNT / 4);

   logic          accept;
   logic          sensor_take;
   logic          pull;
   logic          clear_busy;
   logic          hold;
   logic          dump_pending;
   logic          arm_dump;
   logic          rd_en;
   logic [AW-1:0] rd_angle;
   logic [AW-1:0] dist_addr;
   logic [PW-1:0] spd_addr;
   lsp_wr_type    wr;
   lsp_rd_type    rd;

   assign req_stall   = clear_busy || hold;
   assign accept      = req_valid && !req_stall;
   assign sensor_take = accept && req_payload.action == ACT_SENSOR && !dump_pending;
   assign pull        = accept && req_payload.action == ACT_PULL;

   lsp_parser #(.ANGLE_COUNT(ANGLE_COUNT)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (sensor_take),
      .rx_byte    (req_payload.rx_byte),
      .wr         (wr),
      .dist_addr  (dist_addr),
      .spd_addr   (spd_addr),
      .arm_dump   (arm_dump)
   );

   lsp_tables #(.ANGLE_COUNT(ANGLE_COUNT)) u_tables (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .wr_dist_addr (dist_addr),
      .wr_spd_addr  (spd_addr),
      .rd_en        (rd_en),
      .rd_angle     (rd_angle),
      .rd           (rd),
      .clear_busy   (clear_busy)
   );

   lsp_dump #(.ANGLE_COUNT(ANGLE_COUNT)) u_dump (
      .clock        (clock),
      .reset        (reset),
      .pull         (pull),
      .arm          (arm_dump),
      .rsp_stall    (rsp_stall),
      .rd           (rd),
      .dump_pending (dump_pending),
      .rd_en        (rd_en),
      .rd_angle     (rd_angle),
      .hold         (hold),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

/* tb/lsp_frame_checker.sv */
// ----------------------------------------------------------------------------
// Lidar scan frame checker
// Watches both channels of the lidar scan packet collector. It keeps its own
// copy of the packet parser, the angle tables and the dump counter, queues the
// frame byte that each accepted pull should return, and compares every
// accepted result word against the oldest queued byte.
// ----------------------------------------------------------------------------
module lsp_frame_checker
   import lsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  lsp_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  lsp_rsp_type rsp_payload,
   output int unsigned bad_words,
   output int unsigned words_due
);

   localparam int FRAME_HEAD      = HEAD_LAST + 1;
   localparam int FRAME_BYTES     = FRAME_HEAD + 6 * LSP_ANGLE_COUNT;
   localparam int LAST_ANGLE_BASE = LSP_ANGLE_COUNT - 4;

   localparam logic [1:0] BYTE_DIST_HI = 2'd1;
   localparam logic [1:0] BYTE_STR_HI  = 2'd3;

   logic [4:0]  phase;
   logic [8:0]  angle_base;
   logic [7:0]  low_byte;
   logic [13:0] held_dist;
   logic [13:0] dist_tab [LSP_ANGLE_COUNT];
   logic [15:0] str_tab  [LSP_ANGLE_COUNT];
   logic [15:0] spd_tab  [LSP_ANGLE_COUNT];
   logic        dumping;
   int unsigned frame_pos;
   lsp_rsp_type frame_bytes_due [$];
   int unsigned err_total = 0;

   task automatic note_mismatch(input string what);
      $display("%0t: %s", $time, what);
      err_total++;
   endtask

   task automatic clear_scan();
      int i;
      phase = PH_HUNT;
      angle_base = '0;
      low_byte = '0;
      held_dist = '0;
      dumping = 1'b0;
      frame_pos = 0;
      for (i = 0; i < LSP_ANGLE_COUNT; i++) begin
         dist_tab[i] = '0;
         str_tab[i] = '0;
         spd_tab[i] = '0;
      end
   endtask

   task automatic parse_sensor_byte(input logic [7:0] b);
      int i;
      logic [3:0] step;
      logic [8:0] slot;
      if (phase == PH_HUNT) begin
         if (b == SYNC_BYTE) phase = PH_INDEX;
      end else if (phase == PH_INDEX) begin
         if (b >= INDEX_LOW && b <= INDEX_HIGH) begin
            angle_base = {1'b0, b - INDEX_LOW} << 2;
            phase = PH_SPEED_LO;
         end else begin
            phase = PH_HUNT;
         end
      end else if (phase == PH_SPEED_LO) begin
         low_byte = b;
         phase = PH_SPEED_HI;
      end else if (phase == PH_SPEED_HI) begin
         for (i = 0; i < 4; i++) begin
            if (angle_base + i < LSP_ANGLE_COUNT) spd_tab[angle_base + i] = {b, low_byte};
         end
         phase = PH_READ0;
      end else if (phase >= PH_READ0 && phase <= PH_LAST) begin
         step = 4'(phase - PH_READ0);
         slot = angle_base + step[3:2];
         case (step[1:0])
            BYTE_DIST_HI: held_dist = 14'({b & DIST_HI_MASK, low_byte});
            BYTE_STR_HI: begin
               if (slot < LSP_ANGLE_COUNT) begin
                  dist_tab[slot] = held_dist;
                  str_tab[slot] = {b, low_byte};
               end
            end
            default: low_byte = b;
         endcase
         if (phase == PH_LAST) begin
            phase = PH_HUNT;
            if (angle_base == LAST_ANGLE_BASE) begin
               dumping = 1'b1;
               frame_pos = 0;
            end
         end else begin
            phase = phase + 5'd1;
         end
      end else begin
         phase = PH_HUNT;
      end
   endtask

   function automatic logic [7:0] frame_byte_at(input int unsigned pos);
      int unsigned a;
      logic [2:0] part;
      logic [15:0] v;
      if (pos < FRAME_HEAD) return SYNC_BYTE;
      a = (pos - FRAME_HEAD) / 6;
      part = 3'((pos - FRAME_HEAD) % 6);
      case (part)
         SUB_STR_LO, SUB_STR_HI: v = str_tab[a];
         SUB_SPD_LO, SUB_SPD_HI: v = spd_tab[a];
         default: v = {2'b00, dist_tab[a]};
      endcase
      return part[0] ? v[15:8] : v[7:0];
   endfunction

   task automatic predict_pull();
      lsp_rsp_type due;
      if (dumping) begin
         due.host_byte = frame_byte_at(frame_pos);
         due.frame_last = (frame_pos == FRAME_BYTES - 1);
         frame_bytes_due.push_back(due);
         if (due.frame_last) begin
            dumping = 1'b0;
            frame_pos = 0;
         end else begin
            frame_pos++;
         end
      end
   endtask

   // Results are checked before the request of the same edge is modeled, since
   // a pull cannot return its byte in the cycle it is accepted.
   always @(posedge clock) begin : watch
      lsp_rsp_type due;
      if (reset) begin
         clear_scan();
         frame_bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               note_mismatch($sformatf("result word %02h with nothing due",
                                       rsp_payload.host_byte));
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_payload.host_byte !== due.host_byte)
                  note_mismatch($sformatf("host_byte %02h, expected %02h",
                                          rsp_payload.host_byte, due.host_byte));
               if (rsp_payload.frame_last !== due.frame_last)
                  note_mismatch($sformatf("frame_last %0b, expected %0b",
                                          rsp_payload.frame_last, due.frame_last));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_payload.action == ACT_PULL) predict_pull();
            else if (!dumping) parse_sensor_byte(req_payload.rx_byte);
         end
      end
      bad_words <= err_total;
      words_due <= frame_bytes_due.size();
   end

endmodule

/* tb/lidar_scan_packet_collector_tb.sv */
// ----------------------------------------------------------------------------
// Lidar scan packet collector testbench
// Drives sensor bytes and host pulls into the collector: a stray pull, sync
// bytes, a bad index byte and a directed packet with extreme readings, a full
// frame dump, then random packets, truncated packets and noise, with further
// dumps drained as they arm. Both channels idle at random. A separate checker
// predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module lidar_scan_packet_collector_tb
   import lsp_pkg::*;
();

   localparam int SCAN_WORDS = 1250;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lsp_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lsp_rsp_type rsp_payload;

   logic        steady = 1'b0;
   logic        frame_open = 1'b0;
   int unsigned frames_seen = 0;
   int unsigned sent_words;
   int unsigned bad_words;
   int unsigned words_due;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   lidar_scan_packet_collector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   lsp_frame_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .bad_words   (bad_words),
      .words_due   (words_due)
   );

   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 2) == 0);
   end

   // Tracks frame progress so that a dump armed by random traffic gets drained.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (rsp_payload.frame_last) begin
            frames_seen <= frames_seen + 1;
            frame_open <= 1'b0;
         end else begin
            frame_open <= 1'b1;
         end
      end
   end

   task automatic put_word(input logic act, input logic [7:0] b);
      lsp_req_type w;
      w.action = act;
      w.rx_byte = b;
      if (!steady) begin
         while ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sensor(input logic [7:0] b);
      put_word(ACT_SENSOR, b);
   endtask

   task automatic pull_byte();
      put_word(ACT_PULL, 8'($urandom_range(0, 255)));
   endtask

   // The readings go out from the low byte of body upward.
   task automatic send_packet(input logic [7:0] index, input logic [15:0] speed,
                              input logic [127:0] body);
      int i;
      sensor(SYNC_BYTE);
      sensor(index);
      sensor(speed[7:0]);
      sensor(speed[15:8]);
      for (i = 0; i < 16; i++) sensor(body[8 * i +: 8]);
   endtask

   task automatic drain_frame();
      int unsigned goal;
      int unsigned pulls;
      goal = frames_seen + 1;
      pulls = 0;
      while (frames_seen < goal) begin
         steady <= (pulls >= 600 && pulls < 1000);
         if ($urandom_range(0, 7) == 0) begin
            sensor(8'($urandom_range(0, 255)));
         end else begin
            pull_byte();
            pulls++;
         end
      end
   endtask

   initial begin
      int unsigned r;
      int unsigned n;
      int unsigned waited;
      logic [7:0] index;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      pull_byte();
      sensor(SYNC_BYTE);
      sensor(SYNC_BYTE);
      sensor(SYNC_BYTE);
      sensor(INDEX_LOW - 8'd1);
      send_packet(INDEX_HIGH, 16'hFFFF, 128'h00_01_3F_FF_80_00_C0_00_00_00_00_00_FF_FF_FF_FF);
      drain_frame();

      sent_words = 0;
      while (sent_words < SCAN_WORDS) begin
         if (frame_open) drain_frame();
         steady <= (sent_words >= 500 && sent_words < 800);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            if ($urandom_range(0, 39) == 0) index = INDEX_HIGH;
            else index = 8'(INDEX_LOW + $urandom_range(0, INDEX_HIGH - INDEX_LOW));
            send_packet(index, 16'($urandom), {$urandom, $urandom, $urandom, $urandom});
            sensor(8'($urandom_range(0, 255)));
            sensor(8'($urandom_range(0, 255)));
            sent_words += 22;
         end else if (r < 80) begin
            n = $urandom_range(0, 17);
            sensor(SYNC_BYTE);
            sensor(8'($urandom_range(0, 255)));
            repeat (n) sensor(8'($urandom_range(0, 255)));
            sent_words += n + 2;
         end else if (r < 90) begin
            n = $urandom_range(1, 8);
            repeat (n) sensor(($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                           : 8'($urandom_range(0, 255)));
            sent_words += n;
         end else begin
            pull_byte();
         end
      end

      if (frame_open) drain_frame();
      steady <= 1'b0;
      repeat (20) sensor(8'h00);
      send_packet(INDEX_HIGH, 16'($urandom), {$urandom, $urandom, $urandom, $urandom});
      drain_frame();
      req_valid <= 1'b0;

      @(posedge clock);
      waited = 0;
      while (words_due != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (bad_words == 0 && words_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* lidar_scan_packet_collector.f */
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_parser.sv
hw/rtl/lsp_tables.sv
hw/rtl/lsp_dump.sv
hw/rtl/lidar_scan_packet_collector.sv
tb/lsp_frame_checker.sv
tb/lidar_scan_packet_collector_tb.sv
